@@ sv/ccal_pkg.sv @@
// ccal_pkg: types, operation and target codes and field limits for the clock calendar
// used by ccal_step and clock_calendar_with_alarm; no dependencies
`default_nettype none

package ccal_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD_ONE = 3'd1;
  localparam logic [2:0] OP_ADD_TEN = 3'd2;
  localparam logic [2:0] OP_ARM     = 3'd3;
  localparam logic [2:0] OP_SILENCE = 3'd4;
  localparam logic [2:0] OP_DISARM  = 3'd5;

  localparam logic [2:0] TGT_HOUR       = 3'd0;
  localparam logic [2:0] TGT_MINUTE     = 3'd1;
  localparam logic [2:0] TGT_SECOND     = 3'd2;
  localparam logic [2:0] TGT_DAY        = 3'd3;
  localparam logic [2:0] TGT_ALARM_HOUR = 3'd4;
  localparam logic [2:0] TGT_ALARM_MIN  = 3'd5;
  localparam logic [2:0] TGT_ALARM_DAY  = 3'd6;

  localparam logic [6:0] SEC_LIMIT  = 7'h3C;
  localparam logic [6:0] MIN_LIMIT  = 7'h3C;
  localparam logic [6:0] HOUR_LIMIT = 7'h18;
  localparam logic [6:0] DAY_LIMIT  = 7'h07;
  localparam logic [6:0] BIG_STEP   = 7'd10;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] target;
  } in_item_t;

  typedef struct packed {
    logic [5:0] seconds_now;
    logic [5:0] minutes_now;
    logic [4:0] hours_now;
    logic [2:0] weekday_now;
    logic [4:0] alarm_hours_now;
    logic [5:0] alarm_minutes_now;
    logic [2:0] alarm_weekday_now;
    logic       armed_flag;
    logic       ringing_flag;
    logic       buzzer_level;
  } out_item_t;

  // add a step and clear the field once the sum reaches its limit
  function automatic logic [6:0] step_wrap(logic [6:0] v, logic [6:0] step,
                                           logic [6:0] limit);
    logic [6:0] sum;
    begin
      sum = v + step;
      step_wrap = (sum >= limit) ? 7'd0 : sum;
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/clock_calendar_with_alarm.sv @@
// clock_calendar_with_alarm: time-of-day clock with weekday and alarm, top level
// uses ccal_pkg and ccal_step
//
//   channel | ports                         | payload
//   input   | in_valid, in_ready, in_item   | in_item_t (operation, target)
//   result  | out_valid, out_ready, out_item| out_item_t (clock, alarm, flags)
//
// one item per cycle sustained while out_ready is high; an item passes the input
// register, then the state register, which is also the result register
// rst_n is synchronous: all fields and flags clear to zero, both stages empty
// a result held by out_ready low stalls the input register; one more item is
// still taken into it
`default_nettype none

module clock_calendar_with_alarm
  import ccal_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire            out_ready,
  output out_item_t      out_item
);

  logic      stg_valid_r;
  in_item_t  stg_item_r;
  logic      out_valid_r;
  out_item_t state_r;
  out_item_t state_nxt;
  logic      advance;

  // the staged item moves on when the result register is free or being taken
  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  ccal_step u_step (
    .cur  (state_r),
    .item (stg_item_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_item_r <= in_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = state_r;

endmodule

`default_nettype wire

@@ sv/ccal_step.sv @@
// ccal_step: next clock, calendar and alarm state for one item
// uses ccal_pkg
`default_nettype none

module ccal_step
  import ccal_pkg::*;
(
  input  wire out_item_t cur,
  input  wire in_item_t  item,
  output out_item_t      nxt
);

  logic [6:0] sec_inc, min_inc, hour_inc, day_inc;
  logic [6:0] amin_one, ahour_one, aday_one;
  logic [6:0] sec_ten, min_ten, hour_ten, amin_ten, ahour_ten;
  logic       ten;
  out_item_t  mid;

  always_comb begin
    sec_inc   = step_wrap({1'b0, cur.seconds_now}, 7'd1, SEC_LIMIT);
    min_inc   = step_wrap({1'b0, cur.minutes_now}, 7'd1, MIN_LIMIT);
    hour_inc  = step_wrap({2'b0, cur.hours_now}, 7'd1, HOUR_LIMIT);
    day_inc   = step_wrap({4'b0, cur.weekday_now}, 7'd1, DAY_LIMIT);
    ahour_one = step_wrap({2'b0, cur.alarm_hours_now}, 7'd1, HOUR_LIMIT);
    amin_one  = step_wrap({1'b0, cur.alarm_minutes_now}, 7'd1, MIN_LIMIT);
    aday_one  = step_wrap({4'b0, cur.alarm_weekday_now}, 7'd1, DAY_LIMIT);
    sec_ten   = step_wrap({1'b0, cur.seconds_now}, BIG_STEP, SEC_LIMIT);
    min_ten   = step_wrap({1'b0, cur.minutes_now}, BIG_STEP, MIN_LIMIT);
    hour_ten  = step_wrap({2'b0, cur.hours_now}, BIG_STEP, HOUR_LIMIT);
    ahour_ten = step_wrap({2'b0, cur.alarm_hours_now}, BIG_STEP, HOUR_LIMIT);
    amin_ten  = step_wrap({1'b0, cur.alarm_minutes_now}, BIG_STEP, MIN_LIMIT);
    ten       = (item.operation == OP_ADD_TEN);

    mid = cur;
    case (item.operation)
      OP_TICK: begin
        // ripple carry: each field moves only when the one below wrapped
        mid.seconds_now = sec_inc[5:0];
        if (sec_inc == 7'd0) begin
          mid.minutes_now = min_inc[5:0];
          if (min_inc == 7'd0) begin
            mid.hours_now = hour_inc[4:0];
            if (hour_inc == 7'd0) begin
              mid.weekday_now = day_inc[2:0];
            end
          end
        end
        if (cur.ringing_flag) begin
          mid.buzzer_level = ~cur.buzzer_level;
        end
      end
      OP_ADD_ONE, OP_ADD_TEN: begin
        case (item.target)
          TGT_HOUR:       mid.hours_now = ten ? hour_ten[4:0] : hour_inc[4:0];
          TGT_MINUTE:     mid.minutes_now = ten ? min_ten[5:0] : min_inc[5:0];
          TGT_SECOND:     mid.seconds_now = ten ? sec_ten[5:0] : sec_inc[5:0];
          TGT_DAY:        if (!ten) mid.weekday_now = day_inc[2:0];
          TGT_ALARM_HOUR: mid.alarm_hours_now = ten ? ahour_ten[4:0] : ahour_one[4:0];
          TGT_ALARM_MIN:  mid.alarm_minutes_now = ten ? amin_ten[5:0] : amin_one[5:0];
          TGT_ALARM_DAY:  if (!ten) mid.alarm_weekday_now = aday_one[2:0];
          default: ;
        endcase
      end
      OP_ARM: mid.armed_flag = 1'b1;
      OP_SILENCE: begin
        mid.ringing_flag = 1'b0;
        mid.buzzer_level = 1'b0;
      end
      OP_DISARM: begin
        mid.armed_flag   = 1'b0;
        mid.ringing_flag = 1'b0;
        mid.buzzer_level = 1'b0;
      end
      default: ;
    endcase

    // match check runs after every item on the updated fields
    nxt = mid;
    if (mid.armed_flag && mid.hours_now == mid.alarm_hours_now &&
        mid.minutes_now == mid.alarm_minutes_now &&
        mid.weekday_now == mid.alarm_weekday_now) begin
      nxt.ringing_flag = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ tb/clock_calendar_with_alarm_tb.sv @@
// clock_calendar_with_alarm_tb: self-checking bench for the clock calendar, a directed table
// then planned and random item runs, checked against an in-bench calendar predictor
// depends on ccal_pkg and clock_calendar_with_alarm
`default_nettype none

module clock_calendar_with_alarm_tb;
  import ccal_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [2:0] TGT_NONE   = 3'd7;

  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 200;

  typedef struct packed {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } opening_row_t;

  localparam out_item_t NIL = '0;
  localparam int OPENING_ROWS = 26;
  // first rows start from reset, so only the seconds field moves
  localparam opening_row_t OPENING [OPENING_ROWS] = '{
    '{'{OP_TICK,    TGT_HOUR},       1'b1,
      '{6'd1, 6'd0, 5'd0, 3'd0, 5'd0, 6'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADD_ONE, TGT_SECOND},     1'b1,
      '{6'd2, 6'd0, 5'd0, 3'd0, 5'd0, 6'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADD_TEN, TGT_SECOND},     1'b1,
      '{6'd12, 6'd0, 5'd0, 3'd0, 5'd0, 6'd0, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_ADD_ONE, TGT_HOUR},       1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_HOUR},       1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_HOUR},       1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_HOUR},       1'b0, NIL},   // 21 + 10 wraps to 0
    '{'{OP_ADD_TEN, TGT_MINUTE},     1'b0, NIL},
    '{'{OP_ADD_ONE, TGT_DAY},        1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_DAY},        1'b0, NIL},   // day ignores add ten
    '{'{OP_ADD_ONE, TGT_ALARM_HOUR}, 1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_ALARM_MIN},  1'b0, NIL},
    '{'{OP_ADD_ONE, TGT_ALARM_DAY},  1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_ALARM_DAY},  1'b0, NIL},
    '{'{OP_ADD_ONE, TGT_NONE},       1'b0, NIL},
    '{'{OP_ADD_TEN, TGT_NONE},       1'b0, NIL},
    '{'{OP_SILENCE, TGT_HOUR},       1'b0, NIL},   // silence while quiet
    '{'{OP_ARM,     TGT_ALARM_DAY},  1'b0, NIL},
    '{'{OP_ADD_ONE, TGT_HOUR},       1'b0, NIL},   // 1:10 day 1 hits the alarm
    '{'{OP_TICK,    TGT_NONE},       1'b0, NIL},
    '{'{OP_TICK,    TGT_MINUTE},     1'b0, NIL},
    '{'{OP_SPARE_A, TGT_NONE},       1'b0, NIL},
    '{'{OP_SILENCE, TGT_SECOND},     1'b0, NIL},   // still matching, rings again
    '{'{OP_TICK,    TGT_DAY},        1'b0, NIL},
    '{'{OP_DISARM,  TGT_ALARM_HOUR}, 1'b0, NIL},
    '{'{OP_SPARE_B, TGT_HOUR},       1'b0, NIL}
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  stim_q[$];
  out_item_t readout_q[$];
  out_item_t plan_cal    = '0;
  out_item_t tracked_cal = '0;
  int        phase       = 0;
  int        taken       = 0;
  int        readouts_checked = 0;
  int        err_count   = 0;
  int        quiet_cycles = 0;

  clock_calendar_with_alarm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned roll_over(int unsigned v, int unsigned step,
                                            int unsigned limit);
    return (v + step >= limit) ? 0 : v + step;
  endfunction

  // calendar state after one item; the readout is the whole state
  function automatic out_item_t advance_calendar(out_item_t s, in_item_t it);
    out_item_t   n;
    int unsigned step;
    bit          ten;
    n = s;
    ten = (it.operation == OP_ADD_TEN);
    step = ten ? BIG_STEP : 1;
    case (it.operation)
      OP_TICK: begin
        n.seconds_now = 6'(roll_over(s.seconds_now, 1, SEC_LIMIT));
        if (n.seconds_now == 0) begin
          n.minutes_now = 6'(roll_over(s.minutes_now, 1, MIN_LIMIT));
          if (n.minutes_now == 0) begin
            n.hours_now = 5'(roll_over(s.hours_now, 1, HOUR_LIMIT));
            if (n.hours_now == 0)
              n.weekday_now = 3'(roll_over(s.weekday_now, 1, DAY_LIMIT));
          end
        end
        if (s.ringing_flag) n.buzzer_level = ~s.buzzer_level;
      end
      OP_ADD_ONE, OP_ADD_TEN: begin
        case (it.target)
          TGT_HOUR:       n.hours_now = 5'(roll_over(s.hours_now, step, HOUR_LIMIT));
          TGT_MINUTE:     n.minutes_now = 6'(roll_over(s.minutes_now, step, MIN_LIMIT));
          TGT_SECOND:     n.seconds_now = 6'(roll_over(s.seconds_now, step, SEC_LIMIT));
          TGT_DAY:        if (!ten) n.weekday_now = 3'(roll_over(s.weekday_now, 1, DAY_LIMIT));
          TGT_ALARM_HOUR: n.alarm_hours_now = 5'(roll_over(s.alarm_hours_now, step, HOUR_LIMIT));
          TGT_ALARM_MIN:  n.alarm_minutes_now = 6'(roll_over(s.alarm_minutes_now, step,
                                                             MIN_LIMIT));
          TGT_ALARM_DAY:  if (!ten) n.alarm_weekday_now = 3'(roll_over(s.alarm_weekday_now, 1,
                                                                       DAY_LIMIT));
          default: ;
        endcase
      end
      OP_ARM: n.armed_flag = 1'b1;
      OP_SILENCE: begin
        n.ringing_flag = 1'b0;
        n.buzzer_level = 1'b0;
      end
      OP_DISARM: begin
        n.armed_flag   = 1'b0;
        n.ringing_flag = 1'b0;
        n.buzzer_level = 1'b0;
      end
      default: ;
    endcase
    if (n.armed_flag && n.hours_now == n.alarm_hours_now &&
        n.minutes_now == n.alarm_minutes_now && n.weekday_now == n.alarm_weekday_now)
      n.ringing_flag = 1'b1;
    return n;
  endfunction

  // queue one item and follow it on the planning copy of the calendar
  task automatic put(logic [2:0] op, logic [2:0] tgt);
    in_item_t it;
    it.operation = op;
    it.target = tgt;
    stim_q.push_back(it);
    plan_cal = advance_calendar(plan_cal, it);
  endtask

  task automatic put_ticks(int count);
    repeat (count) put(OP_TICK, 3'($urandom_range(0, 7)));
  endtask

  // walk one field to a goal with add ten and add one, coarse steps first
  task automatic steer(logic [2:0] tgt, int unsigned goal, int unsigned limit);
    int unsigned cur;
    bit          coarse;
    for (int guard = 0; guard < 100; guard++) begin
      case (tgt)
        TGT_HOUR:       cur = plan_cal.hours_now;
        TGT_MINUTE:     cur = plan_cal.minutes_now;
        TGT_SECOND:     cur = plan_cal.seconds_now;
        TGT_DAY:        cur = plan_cal.weekday_now;
        TGT_ALARM_HOUR: cur = plan_cal.alarm_hours_now;
        TGT_ALARM_MIN:  cur = plan_cal.alarm_minutes_now;
        default:        cur = plan_cal.alarm_weekday_now;
      endcase
      if (cur == goal) break;
      // above the goal, add ten runs the field over its limit back to zero
      coarse = (limit > DAY_LIMIT) && (cur > goal || goal - cur >= BIG_STEP);
      put(coarse ? OP_ADD_TEN : OP_ADD_ONE, tgt);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      if (err_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // results first, so a spurious one cannot meet an expectation queued this edge
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          err_count++;
          if (err_count <= PRINT_CAP)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          out_item_t want;
          want = readout_q.pop_front();
          check_field("seconds_now", want.seconds_now, out_item.seconds_now);
          check_field("minutes_now", want.minutes_now, out_item.minutes_now);
          check_field("hours_now", want.hours_now, out_item.hours_now);
          check_field("weekday_now", want.weekday_now, out_item.weekday_now);
          check_field("alarm_hours_now", want.alarm_hours_now, out_item.alarm_hours_now);
          check_field("alarm_minutes_now", want.alarm_minutes_now, out_item.alarm_minutes_now);
          check_field("alarm_weekday_now", want.alarm_weekday_now, out_item.alarm_weekday_now);
          check_field("armed_flag", want.armed_flag, out_item.armed_flag);
          check_field("ringing_flag", want.ringing_flag, out_item.ringing_flag);
          check_field("buzzer_level", want.buzzer_level, out_item.buzzer_level);
        end
        readouts_checked++;
      end
      if (in_valid && in_ready) begin
        tracked_cal = advance_calendar(tracked_cal, in_item);
        if (taken < OPENING_ROWS && OPENING[taken].pinned)
          readout_q.push_back(OPENING[taken].want);
        else
          readout_q.push_back(tracked_cal);
        taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("clock_calendar_with_alarm_tb: done, errors");
      $finish;
    end
  end

  // result side: random stalls by phase, one long hold-off early on
  initial begin
    int stall_pct;
    bit held_off;
    held_off = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && readouts_checked >= 100) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall_pct = (phase == 2) ? 53 : (phase == 3) ? 32 : 0;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int          pick;
    int unsigned ah, am, ad;
    int          idle_pct;

    foreach (OPENING[r]) put(OPENING[r].item.operation, OPENING[r].item.target);

    while (stim_q.size() < OPENING_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // alarm run: set an alarm, park the clock just short of it, tick through
        ah = $urandom_range(0, 23);
        am = $urandom_range(0, 59);
        ad = $urandom_range(0, 6);
        if ($urandom_range(0, 1)) put(OP_DISARM, 3'($urandom_range(0, 7)));
        steer(TGT_ALARM_HOUR, ah, HOUR_LIMIT);
        steer(TGT_ALARM_MIN, am, MIN_LIMIT);
        steer(TGT_ALARM_DAY, ad, DAY_LIMIT);
        steer(TGT_DAY, ad, DAY_LIMIT);
        steer(TGT_HOUR, ah, HOUR_LIMIT);
        steer(TGT_MINUTE, $urandom_range(0, 2) == 0 ? am : (am + 59) % 60, MIN_LIMIT);
        steer(TGT_SECOND, $urandom_range(30, 59), SEC_LIMIT);
        put(OP_ARM, 3'($urandom_range(0, 7)));
        put_ticks($urandom_range(20, 90));
        if ($urandom_range(0, 2) == 0) begin
          put(OP_SILENCE, 3'($urandom_range(0, 7)));
          put_ticks($urandom_range(1, 10));
        end
        if ($urandom_range(0, 1)) put(OP_DISARM, 3'($urandom_range(0, 7)));
      end else if (pick < 70) begin
        // carry run: bring the clock near the end of a minute, hour, day or week
        steer(TGT_DAY, $urandom_range(0, 1) ? 6 : $urandom_range(0, 6), DAY_LIMIT);
        steer(TGT_HOUR, $urandom_range(0, 1) ? 23 : $urandom_range(0, 23), HOUR_LIMIT);
        steer(TGT_MINUTE, $urandom_range(0, 3) ? 59 : $urandom_range(0, 59), MIN_LIMIT);
        steer(TGT_SECOND, $urandom_range(45, 59), SEC_LIMIT);
        put_ticks($urandom_range(15, 80));
      end else begin
        repeat ($urandom_range(5, 30))
          put(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < stim_q.size(); k++) begin
      phase = (k * 4) / stim_q.size();
      idle_pct = (phase == 1) ? 53 : (phase == 3) ? 32 : 0;
      if ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
      end
      in_valid <= 1'b1;
      in_item  <= stim_q[k];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;

    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("clock_calendar_with_alarm_tb: done, clean");
    else
      $display("clock_calendar_with_alarm_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
